@@ rtl/tcc_pkg.sv @@
// Shared types, constants and the multiply-accumulate microprogram of the calibration core.
package tcc_pkg;

  localparam int TOUCH_BITS_DEF   = 12;
  localparam int DISPLAY_BITS_DEF = 11;

  // Linear terms must land in [-2^18, 2^18), offsets in [-2^30, 2^30).
  localparam int LIN_SH = 18;
  localparam int OFS_SH = 30;

  localparam int DIV_W = 26;
  localparam int LIN_W = 19;
  localparam int OFS_W = 31;
  localparam int OUT_FIELDS_W = DIV_W + 4 * LIN_W + 2 * OFS_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int NUM_STEPS = 35;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_SCALE,
    ST_EMIT
  } ctrl_state_t;

  // Multiplier operand A sources
  typedef enum logic [3:0] {
    OPA_A0, OPA_A1, OPA_D0, OPA_D1, OPA_E0, OPA_E1,
    OPA_RX0, OPA_RX1, OPA_RX2, OPA_RY0, OPA_RY1, OPA_RY2
  } opa_sel_t;

  // Multiplier operand B sources
  typedef enum logic [3:0] {
    OPB_B0, OPB_B1, OPB_A1, OPB_D1, OPB_E1,
    OPB_DX0, OPB_DX1, OPB_DX2, OPB_DY0, OPB_DY1, OPB_DY2, OPB_INNER
  } opb_sel_t;

  typedef enum logic [2:0] {
    ACC_NOP,
    ACC_INNER_LOAD,
    ACC_INNER_SUB,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_ST,
    ACC_SUB_ST
  } acc_op_t;

  typedef enum logic [2:0] {
    T_DIV, T_XRX, T_XRY, T_XOFS, T_YRX, T_YRY, T_YOFS
  } term_idx_t;

  typedef struct packed {
    opa_sel_t  sel_a;
    opb_sel_t  sel_b;
    acc_op_t   op;
    term_idx_t dst;
  } ucode_t;

  localparam ucode_t UC_NOP = '{OPA_A0, OPB_B0, ACC_NOP, T_DIV};

  typedef struct packed {
    logic   capture;
    ucode_t uc;
    logic   halve;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
  } dp_status_t;

  // a = rx - rx2, b = ry - ry2, d = dx - dx2, e = dy - dy2.
  // Offsets use a nested product; a NOP lets the inner sum settle before use.
  function automatic ucode_t ucode(input logic [STEP_W-1:0] step);
    ucode_t uc;
    uc = UC_NOP;
    case (step)
      0:  uc = '{OPA_A0,  OPB_B1,    ACC_LOAD,       T_DIV};
      1:  uc = '{OPA_A1,  OPB_B0,    ACC_SUB_ST,     T_DIV};
      2:  uc = '{OPA_D0,  OPB_B1,    ACC_LOAD,       T_XRX};
      3:  uc = '{OPA_D1,  OPB_B0,    ACC_SUB_ST,     T_XRX};
      4:  uc = '{OPA_A0,  OPB_D1,    ACC_LOAD,       T_XRY};
      5:  uc = '{OPA_D0,  OPB_A1,    ACC_SUB_ST,     T_XRY};
      6:  uc = '{OPA_E0,  OPB_B1,    ACC_LOAD,       T_YRX};
      7:  uc = '{OPA_E1,  OPB_B0,    ACC_SUB_ST,     T_YRX};
      8:  uc = '{OPA_A0,  OPB_E1,    ACC_LOAD,       T_YRY};
      9:  uc = '{OPA_E0,  OPB_A1,    ACC_SUB_ST,     T_YRY};
      10: uc = '{OPA_RX2, OPB_DX1,   ACC_INNER_LOAD, T_XOFS};
      11: uc = '{OPA_RX1, OPB_DX2,   ACC_INNER_SUB,  T_XOFS};
      13: uc = '{OPA_RY0, OPB_INNER, ACC_LOAD,       T_XOFS};
      14: uc = '{OPA_RX0, OPB_DX2,   ACC_INNER_LOAD, T_XOFS};
      15: uc = '{OPA_RX2, OPB_DX0,   ACC_INNER_SUB,  T_XOFS};
      17: uc = '{OPA_RY1, OPB_INNER, ACC_ADD,        T_XOFS};
      18: uc = '{OPA_RX1, OPB_DX0,   ACC_INNER_LOAD, T_XOFS};
      19: uc = '{OPA_RX0, OPB_DX1,   ACC_INNER_SUB,  T_XOFS};
      21: uc = '{OPA_RY2, OPB_INNER, ACC_ADD_ST,     T_XOFS};
      22: uc = '{OPA_RX2, OPB_DY1,   ACC_INNER_LOAD, T_YOFS};
      23: uc = '{OPA_RX1, OPB_DY2,   ACC_INNER_SUB,  T_YOFS};
      25: uc = '{OPA_RY0, OPB_INNER, ACC_LOAD,       T_YOFS};
      26: uc = '{OPA_RX0, OPB_DY2,   ACC_INNER_LOAD, T_YOFS};
      27: uc = '{OPA_RX2, OPB_DY0,   ACC_INNER_SUB,  T_YOFS};
      29: uc = '{OPA_RY1, OPB_INNER, ACC_ADD,        T_YOFS};
      30: uc = '{OPA_RX1, OPB_DY0,   ACC_INNER_LOAD, T_YOFS};
      31: uc = '{OPA_RX0, OPB_DY1,   ACC_INNER_SUB,  T_YOFS};
      33: uc = '{OPA_RY2, OPB_INNER, ACC_ADD_ST,     T_YOFS};
      default: uc = UC_NOP;
    endcase
    return uc;
  endfunction

endpackage

@@ rtl/touch_calibration_coefficients_core.sv @@
// Top level of the three-point touch calibration coefficient core.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata: three display points, three raw readings
//   m_*      out  m_tvalid/m_tready  m_tdata: divisor, four linear terms, two offsets
//
// One shared multiplier runs a 35-step multiply-accumulate program. The terms are then
// halved once per cycle until all of them fit; k is the number of halvings, at most 6
// with the default widths. m_tvalid rises when the scaled terms are loaded into the
// output register. A new transaction is accepted only in the idle state.
// Reset (rst, synchronous) clears the controller and the accumulate opcode; no memory
// clearing pass is needed.
// A finished result sits in the output register while the next transaction is taken;
// that transaction's result waits in its last state until the register frees up.
module touch_calibration_coefficients_core #(
  parameter int TOUCH_BITS   = tcc_pkg::TOUCH_BITS_DEF,
  parameter int DISPLAY_BITS = tcc_pkg::DISPLAY_BITS_DEF,
  localparam int IN_TDATA_W  = ((6 * DISPLAY_BITS + 6 * TOUCH_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // low to high: disp_x0, disp_y0, disp_x1, disp_y1, disp_x2, disp_y2,
  //              raw_x0, raw_y0, raw_x1, raw_y1, raw_x2, raw_y2, zero pad
  input  logic [IN_TDATA_W-1:0]           s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // low to high: divisor_term, x_from_raw_x, x_from_raw_y, x_offset,
  //              y_from_raw_x, y_from_raw_y, y_offset, zero pad
  output logic [tcc_pkg::OUT_TDATA_W-1:0] m_tdata
);

  tcc_pkg::dp_cmd_t    cmd;
  tcc_pkg::dp_status_t status;

  tcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  tcc_dp #(
    .TOUCH_BITS   (TOUCH_BITS),
    .DISPLAY_BITS (DISPLAY_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .status  (status),
    .m_tdata (m_tdata)
  );

endmodule

@@ rtl/tcc_dp.sv @@
// Datapath: input capture, shared multiplier with accumulators, term scaling, output register.
module tcc_dp #(
  parameter int TOUCH_BITS   = tcc_pkg::TOUCH_BITS_DEF,
  parameter int DISPLAY_BITS = tcc_pkg::DISPLAY_BITS_DEF,
  localparam int IN_TDATA_W  = ((6 * DISPLAY_BITS + 6 * TOUCH_BITS + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [IN_TDATA_W-1:0]            s_tdata,
  input  tcc_pkg::dp_cmd_t                 cmd,
  output tcc_pkg::dp_status_t              status,
  output logic [tcc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

  localparam int TB    = TOUCH_BITS;
  localparam int DB    = DISPLAY_BITS;
  localparam int MAXB  = (TB > DB) ? TB : DB;
  localparam int AW    = MAXB + 1;
  localparam int BW    = TB + DB + 1;
  localparam int PW    = AW + BW;
  localparam int ACC_W = PW + 1;
  localparam int CMP_W = (ACC_W > 32) ? ACC_W : 32;
  localparam int PAD_W = tcc_pkg::OUT_TDATA_W - tcc_pkg::OUT_FIELDS_W;

  logic [DB-1:0] dx [3];
  logic [DB-1:0] dy [3];
  logic [TB-1:0] rx [3];
  logic [TB-1:0] ry [3];

  logic signed [TB:0] a0, a1, b0, b1;
  logic signed [DB:0] d0, d1, e0, e1;

  logic signed [AW-1:0]    op_a;
  logic signed [BW-1:0]    op_b;
  logic signed [PW-1:0]    prod;
  logic signed [BW-1:0]    inner;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] acc_res;
  tcc_pkg::acc_op_t        op_q;
  tcc_pkg::term_idx_t      dst_q;

  logic signed [ACC_W-1:0] term   [7];
  logic signed [ACC_W-1:0] half_v [7];
  logic signed [CMP_W-1:0] ext    [7];
  logic [6:0]              ok;

  // Capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      for (int i = 0; i < 3; i++) begin
        dx[i] <= s_tdata[(2 * i) * DB +: DB];
        dy[i] <= s_tdata[(2 * i + 1) * DB +: DB];
        rx[i] <= s_tdata[6 * DB + (2 * i) * TB +: TB];
        ry[i] <= s_tdata[6 * DB + (2 * i + 1) * TB +: TB];
      end
    end
  end

  assign a0 = $signed({1'b0, rx[0]}) - $signed({1'b0, rx[2]});
  assign a1 = $signed({1'b0, rx[1]}) - $signed({1'b0, rx[2]});
  assign b0 = $signed({1'b0, ry[0]}) - $signed({1'b0, ry[2]});
  assign b1 = $signed({1'b0, ry[1]}) - $signed({1'b0, ry[2]});
  assign d0 = $signed({1'b0, dx[0]}) - $signed({1'b0, dx[2]});
  assign d1 = $signed({1'b0, dx[1]}) - $signed({1'b0, dx[2]});
  assign e0 = $signed({1'b0, dy[0]}) - $signed({1'b0, dy[2]});
  assign e1 = $signed({1'b0, dy[1]}) - $signed({1'b0, dy[2]});

  always_comb begin
    case (cmd.uc.sel_a)
      tcc_pkg::OPA_A0:  op_a = AW'(a0);
      tcc_pkg::OPA_A1:  op_a = AW'(a1);
      tcc_pkg::OPA_D0:  op_a = AW'(d0);
      tcc_pkg::OPA_D1:  op_a = AW'(d1);
      tcc_pkg::OPA_E0:  op_a = AW'(e0);
      tcc_pkg::OPA_E1:  op_a = AW'(e1);
      tcc_pkg::OPA_RX0: op_a = AW'({1'b0, rx[0]});
      tcc_pkg::OPA_RX1: op_a = AW'({1'b0, rx[1]});
      tcc_pkg::OPA_RX2: op_a = AW'({1'b0, rx[2]});
      tcc_pkg::OPA_RY0: op_a = AW'({1'b0, ry[0]});
      tcc_pkg::OPA_RY1: op_a = AW'({1'b0, ry[1]});
      tcc_pkg::OPA_RY2: op_a = AW'({1'b0, ry[2]});
      default:          op_a = '0;
    endcase
  end

  always_comb begin
    case (cmd.uc.sel_b)
      tcc_pkg::OPB_B0:    op_b = BW'(b0);
      tcc_pkg::OPB_B1:    op_b = BW'(b1);
      tcc_pkg::OPB_A1:    op_b = BW'(a1);
      tcc_pkg::OPB_D1:    op_b = BW'(d1);
      tcc_pkg::OPB_E1:    op_b = BW'(e1);
      tcc_pkg::OPB_DX0:   op_b = BW'({1'b0, dx[0]});
      tcc_pkg::OPB_DX1:   op_b = BW'({1'b0, dx[1]});
      tcc_pkg::OPB_DX2:   op_b = BW'({1'b0, dx[2]});
      tcc_pkg::OPB_DY0:   op_b = BW'({1'b0, dy[0]});
      tcc_pkg::OPB_DY1:   op_b = BW'({1'b0, dy[1]});
      tcc_pkg::OPB_DY2:   op_b = BW'({1'b0, dy[2]});
      tcc_pkg::OPB_INNER: op_b = inner;
      default:            op_b = '0;
    endcase
  end

  // Multiply stage, then accumulate stage in the cycle after
  always_ff @(posedge clk) begin
    prod  <= op_a * op_b;
    dst_q <= cmd.uc.dst;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_q <= tcc_pkg::ACC_NOP;
    end else begin
      op_q <= cmd.uc.op;
    end
  end

  assign prod_ext = ACC_W'(prod);

  always_comb begin
    case (op_q)
      tcc_pkg::ACC_LOAD:   acc_res = prod_ext;
      tcc_pkg::ACC_ADD:    acc_res = acc + prod_ext;
      tcc_pkg::ACC_ADD_ST: acc_res = acc + prod_ext;
      tcc_pkg::ACC_SUB_ST: acc_res = acc - prod_ext;
      default:             acc_res = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_res;
    case (op_q)
      tcc_pkg::ACC_INNER_LOAD: inner <= BW'(prod);
      tcc_pkg::ACC_INNER_SUB:  inner <= inner - BW'(prod);
      default:                 inner <= inner;
    endcase
  end

  // Halving truncates toward zero: odd negatives round up
  always_comb begin
    for (int i = 0; i < 7; i++) begin
      half_v[i] = (term[i] >>> 1)
                + $signed({{(ACC_W-1){1'b0}}, term[i][ACC_W-1] & term[i][0]});
      ext[i]    = CMP_W'(term[i]);
    end
    ok[0] = 1'b1;
    for (int i = 1; i < 7; i++) begin
      if (i == 3 || i == 6) begin
        ok[i] = (&ext[i][CMP_W-1:tcc_pkg::OFS_SH]) | ~(|ext[i][CMP_W-1:tcc_pkg::OFS_SH]);
      end else begin
        ok[i] = (&ext[i][CMP_W-1:tcc_pkg::LIN_SH]) | ~(|ext[i][CMP_W-1:tcc_pkg::LIN_SH]);
      end
    end
  end

  assign status.in_range = &ok;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 7; i++) begin
      if (cmd.halve) begin
        term[i] <= half_v[i];
      end else if ((op_q == tcc_pkg::ACC_ADD_ST || op_q == tcc_pkg::ACC_SUB_ST)
                   && dst_q == tcc_pkg::term_idx_t'(i)) begin
        term[i] <= acc_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {{PAD_W{1'b0}},
                  ext[6][tcc_pkg::OFS_W-1:0],
                  ext[5][tcc_pkg::LIN_W-1:0],
                  ext[4][tcc_pkg::LIN_W-1:0],
                  ext[3][tcc_pkg::OFS_W-1:0],
                  ext[2][tcc_pkg::LIN_W-1:0],
                  ext[1][tcc_pkg::LIN_W-1:0],
                  ext[0][tcc_pkg::DIV_W-1:0]};
    end
  end

endmodule

@@ rtl/tcc_ctrl.sv @@
// Controller: sequences capture, the multiply-accumulate program, scaling and output hand-off.
module tcc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output tcc_pkg::dp_cmd_t    cmd,
  input  tcc_pkg::dp_status_t status
);

  tcc_pkg::ctrl_state_t          state, state_next;
  logic [tcc_pkg::STEP_W-1:0]    step, step_next;
  logic                          out_valid, out_valid_next;
  logic                          last_step;

  assign last_step = (step == tcc_pkg::STEP_W'(tcc_pkg::NUM_STEPS - 1));

  always_comb begin
    state_next = state;
    case (state)
      tcc_pkg::ST_IDLE:  if (s_tvalid) state_next = tcc_pkg::ST_RUN;
      tcc_pkg::ST_RUN:   if (last_step) state_next = tcc_pkg::ST_SCALE;
      tcc_pkg::ST_SCALE: if (status.in_range) state_next = tcc_pkg::ST_EMIT;
      tcc_pkg::ST_EMIT:  if (!out_valid || m_tready) state_next = tcc_pkg::ST_IDLE;
      default:           state_next = tcc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready     = (state == tcc_pkg::ST_IDLE);
    cmd.capture  = (state == tcc_pkg::ST_IDLE) && s_tvalid;
    cmd.uc       = (state == tcc_pkg::ST_RUN) ? tcc_pkg::ucode(step) : tcc_pkg::UC_NOP;
    cmd.halve    = (state == tcc_pkg::ST_SCALE) && !status.in_range;
    cmd.load_out = (state == tcc_pkg::ST_EMIT) && (!out_valid || m_tready);
    step_next    = (state == tcc_pkg::ST_RUN) ? step + 1'b1 : '0;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tcc_pkg::ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == tcc_pkg::ST_RUN && step == '0))
    else $error("accepted transaction did not start the program at step zero");

  a_run_full: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == tcc_pkg::ST_RUN && state != tcc_pkg::ST_RUN)
      |-> $past(step) == tcc_pkg::STEP_W'(tcc_pkg::NUM_STEPS - 1))
    else $error("program left before its last step");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || m_tready))
    else $error("output register overwritten while a result is pending");

  a_halve_needed: assert property (@(posedge clk) disable iff (rst)
    cmd.halve |-> (!status.in_range && state == tcc_pkg::ST_SCALE))
    else $error("terms halved although already in range");

endmodule
